// ===== rtl/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and codes for the hierarchical timer wheel core.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

	localparam int TW = 50;

	typedef logic [TW-1:0] time_t;
	typedef logic [TW+1:0] wtime_t;

	typedef enum logic [1:0] {
		OP_ADVANCE = 2'd0,
		OP_ADD     = 2'd1,
		OP_DELETE  = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_RANGE  = 3'd1,
		ST_BUSY   = 3'd2,
		ST_IDLE   = 3'd3,
		ST_BEHIND = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] level;
		time_t      expiry;
	} entry_t;

	typedef struct packed {
		wtime_t     next_touch;
		logic       past;
		logic [2:0] place_level;
		logic       keep;
		logic [2:0] new_level;
		logic       fire;
	} eval_t;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN_RD = 6'b000010,
		S_SCAN_EV = 6'b000100,
		S_VIS_RD  = 6'b001000,
		S_VIS_EV  = 6'b010000,
		S_FLUSH   = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/hierarchical_timer_wheel_core.sv =====
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_core
// Five-level timing wheel over a table of timer handles: add, delete and
// advance time, reporting fired timers one per response.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake                    contents
// s_axis   in   s_axis_tvalid/s_axis_tready  opcode (tuser), handle, time
// m_axis   out  m_axis_tvalid/m_axis_tready  status, fired flag, handle, time, last
//
// add, delete and a behind target finish in the accept cycle; the response
// sits in the output register until taken
// an advance scans the table once per jiffy with timers due (per entry a
// memory read, then an evaluate) and walks it again to cascade and fire,
// then makes a closing scan unless the target itself is touched, and ends
// in a flush state
// reset clears time and armed flags at once; entry memory needs no clearing
// a stalled output holds the walk on the entry that wants to fire
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timer_wheel_core
	import htw_pkg::*;
#(
	parameter int SLOT_BITS = 8,
	parameter int TIMERS    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // timer_handle[5:0], time_value[55:6]
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // status[2:0], expired_valid[3],
	                                        // expired_handle[9:4], current_time[59:10]
	output logic             m_axis_tlast
);

	localparam int HW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [HW-1:0] LAST_IDX = HW'(TIMERS - 1);

	state_t          state_q;
	logic [HW-1:0]   idx_q;
	logic [TIMERS-1:0] armed_q;
	time_t           cur_q, tv_q, j_q;
	wtime_t          best_q;
	logic            any_q;
	logic            pend_v_q;
	logic [5:0]      pend_h_q;

	// output register
	logic            out_v_q;
	status_t         out_st_q;
	logic            out_fv_q;
	logic [5:0]      out_h_q;
	time_t           out_t_q;
	logic            out_last_q;

	// request fields
	opcode_t         in_op;
	logic [5:0]      in_h;
	time_t           in_tv;
	logic            h_ok;

	assign in_op = opcode_t'(s_axis_tuser);
	assign in_h  = s_axis_tdata[5:0];
	assign in_tv = s_axis_tdata[55:6];
	assign h_ok  = {1'b0, in_h} < 7'(TIMERS);

	logic out_free;
	assign out_free      = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// entry memory
	logic          mem_we, mem_re;
	logic [HW-1:0] mem_wa;
	entry_t        mem_wd, mem_rd;

	htw_mem #(.DEPTH(TIMERS), .AW(HW)) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (mem_re),
		.rd_addr (idx_q),
		.rd_data (mem_rd)
	);

	// wheel arithmetic: in idle it places the incoming add, otherwise it
	// works on the entry just read against the jiffy in hand
	time_t      ev_now, ev_exp;
	logic [2:0] ev_lvl;
	eval_t      ev;

	always_comb begin
		if (state_q == S_IDLE) begin
			ev_now = cur_q;
			ev_exp = in_tv;
			ev_lvl = 3'd1;
		end else if (state_q == S_SCAN_EV) begin
			ev_now = j_q;
			ev_exp = mem_rd.expiry;
			ev_lvl = mem_rd.level;
		end else begin
			ev_now = best_q[TW-1:0];
			ev_exp = mem_rd.expiry;
			ev_lvl = mem_rd.level;
		end
	end

	htw_eval #(.SLOT_BITS(SLOT_BITS)) u_eval (
		.now    (ev_now),
		.level  (ev_lvl),
		.expiry (ev_exp),
		.res    (ev)
	);

	// status of the request on offer, ok means it takes effect
	status_t in_st;

	always_comb begin
		in_st = ST_OK;
		unique case (in_op)
			OP_ADVANCE: begin
				if (in_tv < cur_q) in_st = ST_BEHIND;
			end
			OP_ADD: begin
				if (ev.past) begin
					in_st = ST_RANGE;
				end else if (!h_ok || armed_q[in_h[HW-1:0]]) begin
					in_st = ST_BUSY;
				end
			end
			OP_DELETE: begin
				if (!h_ok || !armed_q[in_h[HW-1:0]]) in_st = ST_IDLE;
			end
			OP_NONE: begin
				in_st = ST_OK;
			end
		endcase
	end

	logic   cur_armed;
	logic   any_n;
	wtime_t best_n;
	logic   stall_v;
	logic   idx_last;
	logic   out_load;

	assign cur_armed = armed_q[idx_q];
	assign any_n     = any_q || cur_armed;
	assign best_n    = (cur_armed && (!any_q || ev.next_touch < best_q)) ?
		ev.next_touch : best_q;
	assign stall_v   = cur_armed && ev.fire && pend_v_q && !out_free;
	assign idx_last  = idx_q == LAST_IDX;

	// a new response enters the output register
	assign out_load = ((state_q == S_IDLE) && acc
			&& !((in_op == OP_ADVANCE) && (in_st == ST_OK)))
		|| ((state_q == S_VIS_EV) && cur_armed && ev.fire && pend_v_q && !stall_v)
		|| ((state_q == S_FLUSH) && out_free);

	assign mem_re = (state_q == S_SCAN_RD) || (state_q == S_VIS_RD);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = mem_rd;
		if (state_q == S_IDLE) begin
			mem_wa = in_h[HW-1:0];
			mem_wd = '{level: ev.place_level, expiry: in_tv};
			mem_we = acc && (in_op == OP_ADD) && !ev.past && h_ok && !armed_q[in_h[HW-1:0]];
		end else if (state_q == S_VIS_EV) begin
			mem_wd = '{level: ev.new_level, expiry: mem_rd.expiry};
			mem_we = cur_armed && !stall_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			armed_q  <= '0;
			cur_q    <= '0;
			any_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						out_st_q   <= in_st;
						out_fv_q   <= 1'b0;
						out_h_q    <= '0;
						out_t_q    <= cur_q;
						out_last_q <= 1'b1;
						unique case (in_op)
							OP_ADVANCE: begin
								if (in_st == ST_OK) begin
									tv_q     <= in_tv;
									j_q      <= cur_q;
									any_q    <= 1'b0;
									pend_v_q <= 1'b0;
									idx_q    <= '0;
									state_q  <= S_SCAN_RD;
								end
							end
							OP_ADD: begin
								if (in_st == ST_OK) begin
									armed_q[in_h[HW-1:0]] <= 1'b1;
								end
							end
							OP_DELETE: begin
								if (in_st == ST_OK) begin
									armed_q[in_h[HW-1:0]] <= 1'b0;
								end
							end
							OP_NONE: begin
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_EV;
				end
				S_SCAN_EV: begin
					any_q  <= any_n;
					best_q <= best_n;
					if (idx_last) begin
						idx_q <= '0;
						if (!any_n || best_n > {2'b00, tv_q}) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_VIS_RD;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_VIS_RD: begin
					state_q <= S_VIS_EV;
				end
				S_VIS_EV: begin
					if (!stall_v) begin
						if (cur_armed) begin
							armed_q[idx_q] <= ev.keep;
							if (ev.fire) begin
								if (pend_v_q) begin
									out_st_q   <= ST_OK;
									out_fv_q   <= 1'b1;
									out_h_q    <= pend_h_q;
									out_t_q    <= tv_q;
									out_last_q <= 1'b0;
								end
								pend_v_q <= 1'b1;
								pend_h_q <= 6'(idx_q);
							end
						end
						if (idx_last) begin
							idx_q <= '0;
							if (best_q == {2'b00, tv_q}) begin
								state_q <= S_FLUSH;
							end else begin
								j_q     <= best_q[TW-1:0] + 1'b1;
								any_q   <= 1'b0;
								state_q <= S_SCAN_RD;
							end
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_VIS_RD;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_st_q   <= ST_OK;
						out_fv_q   <= pend_v_q;
						out_h_q    <= pend_v_q ? pend_h_q : 6'd0;
						out_t_q    <= tv_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						cur_q      <= tv_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0000, out_t_q, out_h_q, out_fv_q, out_st_q};
	assign m_axis_tlast  = out_last_q;

	// requests are only taken with the sequencer at rest
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE)
		else $error("request taken while an advance is running");

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");

	// a held fired timer never outlives its advance
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> state_q != S_IDLE)
		else $error("pending fired timer left behind");

	// a flush with free output always returns to idle with a last response
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) && out_free |=> m_axis_tvalid && m_axis_tlast)
		else $error("advance closed without last response");

endmodule

`default_nettype wire

// ===== rtl/htw_mem.sv =====
// ----------------------------------------------------------------------------
// htw_mem
// Timer entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_mem
	import htw_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/htw_eval.sv =====
// ----------------------------------------------------------------------------
// htw_eval
// Per-entry wheel arithmetic: placement level, next touch, cascade and fire.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_eval
	import htw_pkg::*;
#(
	parameter int SLOT_BITS = 8
) (
	input  wire time_t      now,
	input  wire logic [2:0] level,
	input  wire time_t      expiry,
	output eval_t           res
);

	localparam int SB = SLOT_BITS;

	function automatic logic [2:0] lev_of(input time_t diff);
		logic [2:0] r;
		r = 3'd5;
		if ((diff >> (4*SB)) == '0) r = 3'd4;
		if ((diff >> (3*SB)) == '0) r = 3'd3;
		if ((diff >> (2*SB)) == '0) r = 3'd2;
		if ((diff >> SB) == '0) r = 3'd1;
		return r;
	endfunction

	// low-bit mask below a level's slot field, and the field's shift
	function automatic wtime_t low_mask(input logic [2:0] lv);
		wtime_t m;
		unique case (lv)
			3'd2:    m = (wtime_t'(1) << SB) - 1'b1;
			3'd3:    m = (wtime_t'(1) << (2*SB)) - 1'b1;
			3'd4:    m = (wtime_t'(1) << (3*SB)) - 1'b1;
			3'd5:    m = (wtime_t'(1) << (4*SB)) - 1'b1;
			3'd6:    m = (wtime_t'(1) << (5*SB)) - 1'b1;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic wtime_t field(input wtime_t v, input logic [2:0] lv);
		wtime_t r;
		unique case (lv)
			3'd2:    r = v >> SB;
			3'd3:    r = v >> (2*SB);
			3'd4:    r = v >> (3*SB);
			3'd5:    r = v >> (4*SB);
			default: r = v;
		endcase
		return r & ((wtime_t'(1) << SB) - 1'b1);
	endfunction

	function automatic wtime_t place_slot(input wtime_t s, input logic [2:0] lv);
		wtime_t r;
		unique case (lv)
			3'd2:    r = s << SB;
			3'd3:    r = s << (2*SB);
			3'd4:    r = s << (3*SB);
			3'd5:    r = s << (4*SB);
			default: r = s;
		endcase
		return r;
	endfunction

	wtime_t     j_w, e_w, per_m, slot, nt0, nt1, lowspan, flo;
	time_t      diff;
	logic       hit, keep;
	logic [2:0] nl;

	always_comb begin
		j_w  = {2'b00, now};
		e_w  = {2'b00, expiry};
		diff = expiry - now;
		res.past        = expiry < now;
		res.place_level = lev_of(diff);

		// next touch at or after now
		slot  = field(e_w, level);
		per_m = low_mask(level + 3'd1);
		nt0   = (j_w & ~per_m) | place_slot(slot, level);
		nt1   = (nt0 < j_w) ? nt0 + per_m + 1'b1 : nt0;
		lowspan = wtime_t'(1) << (4*SB);
		flo     = e_w & ~(lowspan - 1'b1);
		if (level == 3'd5 && e_w >= nt1 && (e_w - nt1) >= lowspan && flo > nt1) begin
			res.next_touch = flo;
		end else begin
			res.next_touch = nt1;
		end

		// cascade at this jiffy, then fire from level one
		hit = (level >= 3'd2) && ((j_w & low_mask(level)) == '0)
			&& (slot == field(j_w, level));
		keep = 1'b1;
		nl   = level;
		if (hit) begin
			keep = !res.past;
			nl   = res.place_level;
		end
		res.fire = keep && (nl == 3'd1) && (field(e_w, 3'd1) == field(j_w, 3'd1));
		res.keep      = keep && !res.fire;
		res.new_level = nl;
	end

endmodule

`default_nettype wire
